// ===== rtl/cdll_pkg.sv =====
// Package for the circular doubly linked list block.
// Holds the request and result word types, function codes and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cdll_pkg;

  // Fixed field widths of the request and result words.
  localparam int unsigned FUNC_BITS  = 3;
  localparam int unsigned DATA_BITS  = 32;
  localparam int unsigned POS_BITS   = 6;
  localparam int unsigned COUNT_BITS = 6;

  // Request function codes. The two codes above delete-tail are no-ops.
  localparam logic [FUNC_BITS-1:0] FN_INS_HEAD = 3'd0;
  localparam logic [FUNC_BITS-1:0] FN_INS_POS  = 3'd1;
  localparam logic [FUNC_BITS-1:0] FN_INS_TAIL = 3'd2;
  localparam logic [FUNC_BITS-1:0] FN_DEL_HEAD = 3'd3;
  localparam logic [FUNC_BITS-1:0] FN_DEL_POS  = 3'd4;
  localparam logic [FUNC_BITS-1:0] FN_DEL_TAIL = 3'd5;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // Request word.
  typedef struct packed {
    logic [FUNC_BITS-1:0]        func;
    logic signed [DATA_BITS-1:0] value;
    logic [POS_BITS-1:0]         position;
  } req_t;

  // Result word.
  typedef struct packed {
    status_e                     status;
    logic signed [DATA_BITS-1:0] removed_value;
    logic [COUNT_BITS-1:0]       count_after;
  } res_t;

endpackage : cdll_pkg

`default_nettype wire

// ===== rtl/circular_doubly_linked_list.sv =====
// Top level of the circular doubly linked list block.
// Uses cdll_pkg for the request and result word types and the codes.
//
// Usage: a request word is taken on req_i at a clock edge where start is high
// and busy is low. Each request gives exactly one result word on res_o, marked
// by done_o for one cycle; the receiver takes it at the edge that ends that
// cycle and cannot hold it off. busy is low again in the cycle done_o is high,
// so the next request may be started while the previous result is shown.
// Rejected and no-op requests (bad position, empty, full) finish from idle.
// A delete reads its node and then unlinks it; an insert at head or tail
// (also positional at either end) fills the new node and then points its
// neighbors at it. Other positional requests first walk along the next-link
// memory, one link per cycle through its registered read, so they take longer
// the further the position is from the head. Node values and links sit in
// three synchronous memories; the free map, head, tail and count are
// flip-flops. Reset empties the list at once: no clearing pass is needed,
// since only linked nodes are ever read.
`timescale 1ns / 1ps
`default_nettype none

module circular_doubly_linked_list #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire cdll_pkg::req_t req_i,
  output logic               done_o,
  output cdll_pkg::res_t     res_o
);

  import cdll_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = ((CNT_W > POS_BITS) ? CNT_W : POS_BITS) + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_INS1 = 4'b0100,
    S_INS2 = 4'b1000
  } state_e;

  // Control state.
  state_e                state_q, state_d;
  logic [IDX_W-1:0]      head_q, head_d;
  logic [IDX_W-1:0]      tail_q, tail_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CAPACITY-1:0]   in_use_q, in_use_d;
  logic [IDX_W-1:0]      steps_q, steps_d;
  logic                  done_q, done_d;

  // Per-request working registers.
  logic signed [VALUE_BITS-1:0] val_q, val_d;
  logic [IDX_W-1:0]      new_q, new_d;
  logic [IDX_W-1:0]      pred_q, pred_d;
  logic [IDX_W-1:0]      succ_q, succ_d;
  logic [IDX_W-1:0]      cur_q, cur_d;
  logic                  is_del_q, is_del_d;
  logic                  set_head_q, set_head_d;
  logic                  set_tail_q, set_tail_d;
  res_t                  res_q, res_d;

  // Node memories and their ports.
  logic signed [VALUE_BITS-1:0] val_mem [0:CAPACITY-1];
  logic [IDX_W-1:0]      next_mem [0:CAPACITY-1];
  logic [IDX_W-1:0]      prev_mem [0:CAPACITY-1];
  logic signed [VALUE_BITS-1:0] rd_val_q;
  logic [IDX_W-1:0]      rd_next_q;
  logic [IDX_W-1:0]      rd_prev_q;
  logic [IDX_W-1:0]      rd_addr;
  logic                  val_we;
  logic [IDX_W-1:0]      val_wa;
  logic                  next_we;
  logic [IDX_W-1:0]      next_wa;
  logic [IDX_W-1:0]      next_wd;
  logic                  prev_we;
  logic [IDX_W-1:0]      prev_wa;
  logic [IDX_W-1:0]      prev_wd;

  // Lowest free node: isolate the lowest clear bit, then encode it.
  logic [CAPACITY-1:0]   free_oh;
  logic [IDX_W-1:0]      free_idx;

  always_comb begin
    free_oh  = ~in_use_q & (in_use_q + CAPACITY'(1));
    free_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (free_oh[i]) begin
        free_idx = free_idx | IDX_W'(i);
      end
    end
  end

  // Read address: the entry node in idle, the next link while walking.
  always_comb begin
    unique case (state_q)
      S_IDLE:  rd_addr = (req_i.func == FN_DEL_TAIL) ? tail_q : head_q;
      S_WALK:  rd_addr = rd_next_q;
      default: rd_addr = head_q;
    endcase
  end

  // Request decode, walk control and link updates.
  always_comb begin
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             empty;
    logic             full;
    logic             edge_ins;
    logic             at_head;

    pos_ext  = CMP_W'(req_i.position);
    cnt_ext  = CMP_W'(count_q);
    empty    = (count_q == '0);
    full     = (count_q == CNT_W'(CAPACITY));
    edge_ins = 1'b0;
    at_head  = 1'b0;

    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    in_use_d   = in_use_q;
    steps_d    = steps_q;
    done_d     = 1'b0;
    val_d      = val_q;
    new_d      = new_q;
    pred_d     = pred_q;
    succ_d     = succ_q;
    cur_d      = cur_q;
    is_del_d   = is_del_q;
    set_head_d = set_head_q;
    set_tail_d = set_tail_q;
    res_d.status        = ST_DONE;
    res_d.removed_value = '0;

    val_we  = 1'b0;
    val_wa  = new_q;
    next_we = 1'b0;
    next_wa = new_q;
    next_wd = succ_q;
    prev_we = 1'b0;
    prev_wa = new_q;
    prev_wd = pred_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          val_d      = VALUE_BITS'(req_i.value);
          new_d      = free_idx;
          cur_d      = rd_addr;
          set_head_d = 1'b0;
          set_tail_d = 1'b0;
          unique case (req_i.func)
            FN_INS_HEAD: begin
              edge_ins = 1'b1;
              at_head  = 1'b1;
            end
            FN_INS_TAIL: begin
              edge_ins = 1'b1;
            end
            FN_INS_POS: begin
              if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
                done_d       = 1'b1;
                res_d.status = ST_BADPOS;
              end else if (pos_ext == CMP_W'(1)) begin
                edge_ins = 1'b1;
                at_head  = 1'b1;
              end else if (pos_ext == cnt_ext + CMP_W'(1)) begin
                edge_ins = 1'b1;
              end else if (full) begin
                done_d       = 1'b1;
                res_d.status = ST_FULL;
              end else begin
                // Walk to the predecessor, position minus two links on.
                is_del_d = 1'b0;
                steps_d  = IDX_W'(pos_ext - CMP_W'(2));
                state_d  = S_WALK;
              end
            end
            FN_DEL_HEAD, FN_DEL_TAIL: begin
              if (empty) begin
                done_d       = 1'b1;
                res_d.status = ST_EMPTY;
              end else begin
                is_del_d = 1'b1;
                steps_d  = '0;
                state_d  = S_WALK;
              end
            end
            FN_DEL_POS: begin
              if (pos_ext == '0 || pos_ext > cnt_ext) begin
                done_d       = 1'b1;
                res_d.status = ST_BADPOS;
              end else begin
                is_del_d = 1'b1;
                steps_d  = IDX_W'(pos_ext - CMP_W'(1));
                state_d  = S_WALK;
              end
            end
            default: begin
              // Unused codes change nothing.
              done_d = 1'b1;
            end
          endcase

          // Insert next to the head or tail needs no read: link between the
          // tail and the head, or to itself on an empty list.
          if (edge_ins) begin
            if (full) begin
              done_d       = 1'b1;
              res_d.status = ST_FULL;
            end else begin
              pred_d     = empty ? free_idx : tail_q;
              succ_d     = empty ? free_idx : head_q;
              set_head_d = empty | at_head;
              set_tail_d = empty | ~at_head;
              state_d    = S_INS1;
            end
          end
        end
      end

      S_WALK: begin
        if (steps_q != '0) begin
          // Follow one next link; its data arrives next cycle.
          steps_d = steps_q - IDX_W'(1);
          cur_d   = rd_next_q;
        end else if (is_del_q) begin
          // Unlink the node just read and free it.
          if (count_q == CNT_W'(1)) begin
            head_d = '0;
            tail_d = '0;
          end else begin
            next_we = 1'b1;
            next_wa = rd_prev_q;
            next_wd = rd_next_q;
            prev_we = 1'b1;
            prev_wa = rd_next_q;
            prev_wd = rd_prev_q;
            if (cur_q == head_q) begin
              head_d = rd_next_q;
            end
            if (cur_q == tail_q) begin
              tail_d = rd_prev_q;
            end
          end
          in_use_d[cur_q]     = 1'b0;
          count_d             = count_q - CNT_W'(1);
          res_d.removed_value = DATA_BITS'(rd_val_q);
          done_d              = 1'b1;
          state_d             = S_IDLE;
        end else begin
          // Predecessor found; its successor is the word just read.
          pred_d  = cur_q;
          succ_d  = rd_next_q;
          state_d = S_INS1;
        end
      end

      S_INS1: begin
        // Fill the new node.
        val_we  = 1'b1;
        val_wa  = new_q;
        next_we = 1'b1;
        next_wa = new_q;
        next_wd = succ_q;
        prev_we = 1'b1;
        prev_wa = new_q;
        prev_wd = pred_q;
        state_d = S_INS2;
      end

      S_INS2: begin
        // Point the neighbors at the new node.
        next_we = 1'b1;
        next_wa = pred_q;
        next_wd = new_q;
        prev_we = 1'b1;
        prev_wa = succ_q;
        prev_wd = new_q;
        if (set_head_q) begin
          head_d = new_q;
        end
        if (set_tail_q) begin
          tail_d = new_q;
        end
        in_use_d[new_q] = 1'b1;
        count_d         = count_q + CNT_W'(1);
        done_d          = 1'b1;
        state_d         = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.count_after = COUNT_BITS'(count_d);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      in_use_q <= '0;
      steps_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      in_use_q <= in_use_d;
      steps_q  <= steps_d;
      done_q   <= done_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    new_q      <= new_d;
    pred_q     <= pred_d;
    succ_q     <= succ_d;
    cur_q      <= cur_d;
    is_del_q   <= is_del_d;
    set_head_q <= set_head_d;
    set_tail_q <= set_tail_d;
    res_q      <= res_d;
  end

  // Node memories: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_wa] <= val_q;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    rd_val_q  <= val_mem[rd_addr];
    rd_next_q <= next_mem[rd_addr];
    rd_prev_q <= prev_mem[rd_addr];
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // The free map always agrees with the count.
  a_map_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(in_use_q) == int'(count_q))
    else $error("free map and count disagree");

  // The count never passes the pool size.
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  // An empty list has head and tail at node zero.
  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == '0 && tail_q == '0))
    else $error("empty list with stray head or tail");

  // A result word is shown only when the block is back in idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result while busy");

  // A walk that is started always ends in a result or an insert.
  a_walk_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && steps_q == '0) |=> (done_q || state_q == S_INS1))
    else $error("walk ended without action");

endmodule : circular_doubly_linked_list

`default_nettype wire
